/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/spzl_pkg.sv */
package spzl_pkg;

   localparam int MAX_LEVEL_DEF = 4;
   localparam int COMP_BITS_DEF = 16;
   localparam int NUM_FACES     = 20;
   localparam int STORED_LEVELS = 4;
   localparam int ZONE_W        = 13;
   localparam int VEC_W         = 16;

   localparam longint CORNER_A_Q30 = 64'sd913379351;
   localparam longint CORNER_B_Q30 = 64'sd564499483;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   localparam int FACE_TABLE [NUM_FACES][3] = '{
      '{ 1, 0,10}, '{ 0, 1, 9}, '{ 0, 9, 6}, '{ 9, 8, 6}, '{ 0, 7,10},
      '{ 6, 7, 0}, '{ 7, 6, 3}, '{ 6, 8, 3}, '{11,10, 7}, '{ 7, 3,11},
      '{ 3, 2,11}, '{ 2, 3, 8}, '{10,11, 4}, '{ 2, 4,11}, '{ 5, 4, 2},
      '{ 2, 8, 5}, '{ 4, 1,10}, '{ 4, 5, 1}, '{ 5, 9, 1}, '{ 8, 9, 5}
   };

   // +1 = +a, -1 = -a, +2 = +b, -2 = -b
   localparam int CORNER_PATTERN [12][3] = '{
      '{ 1,-2, 0}, '{ 1, 2, 0}, '{-1, 2, 0}, '{-1,-2, 0},
      '{ 0, 1,-2}, '{ 0, 1, 2}, '{ 0,-1, 2}, '{ 0,-1,-2},
      '{-2, 0, 1}, '{ 2, 0, 1}, '{ 2, 0,-1}, '{-2, 0,-1}
   };

   // cyclic successors of a component or corner index
   localparam int NEXT1 [3] = '{1, 2, 0};
   localparam int NEXT2 [3] = '{2, 0, 1};

   typedef struct packed {
      logic              op;
      logic [1:0]        load_level;
      logic [10:0]       load_index;
      logic [1:0]        load_edge;
      logic [VEC_W-1:0]  vx;
      logic [VEC_W-1:0]  vy;
      logic [VEC_W-1:0]  vz;
      logic [2:0]        lvl;
      logic [ZONE_W-1:0] zone;
      logic              not_found;
   } item_type;

   function automatic longint round_q30(longint q30, int frac);
      int sh;
      sh = 30 - frac;
      return (q30 + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint corner_comp(int k, int j, int frac);
      longint a;
      longint b;
      int     p;
      a = round_q30(CORNER_A_Q30, frac);
      b = round_q30(CORNER_B_Q30, frac);
      p = CORNER_PATTERN[k][j];
      case (p)
         1:       return a;
         -1:      return -a;
         2:       return b;
         -2:      return -b;
         default: return 64'sd0;
      endcase
   endfunction

   // component j of corner(e) x corner(e+1) of face f
   function automatic longint face_cross(int f, int e, int j, int frac);
      int ka;
      int kb;
      ka = FACE_TABLE[f][e];
      kb = FACE_TABLE[f][NEXT1[e]];
      return corner_comp(ka, NEXT1[j], frac) * corner_comp(kb, NEXT2[j], frac)
           - corner_comp(ka, NEXT2[j], frac) * corner_comp(kb, NEXT1[j], frac);
   endfunction

endpackage

/* src/sphere_point_zone_locator.sv */
// Icosahedral zone locator. A locate item returns one result (zone, level,
// not_found); a load item writes one edge midpoint of one triangle into the
// store of its level and returns nothing. The pipeline takes one item per
// cycle while it is not held, through these stages: input register, two
// base-face stages, then four stages per level (midpoint read, cross
// products, triple-product signs, child select) and the result register.
// The whole pipeline holds while a result waits on rsp_ready.
`include "assert_macros.svh"
module sphere_point_zone_locator import spzl_pkg::*; #(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF,
   parameter int COMP_BITS = COMP_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [1:0]        req_load_level,
   input  logic [10:0]       req_load_index,
   input  logic [1:0]        req_load_edge,
   input  logic signed [15:0] req_vec_x,
   input  logic signed [15:0] req_vec_y,
   input  logic signed [15:0] req_vec_z,
   input  logic [2:0]        req_search_level,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [12:0]       rsp_zone,
   output logic [2:0]        rsp_zone_level,
   output logic              rsp_not_found
);

   localparam int CW = COMP_BITS < VEC_W ? COMP_BITS : VEC_W;
   localparam int SH = VEC_W - CW;

   logic     adv;
   logic     in_valid_ff;
   item_type in_item_ff;
   item_type in_item_in;
   logic     chain_valid [MAX_LEVEL+1];
   item_type chain_item  [MAX_LEVEL+1];
   logic     rsp_valid_ff;
   logic [12:0] rsp_zone_ff;
   logic [2:0]  rsp_zone_level_ff;
   logic        rsp_not_found_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      in_item_in.op         = req_op;
      in_item_in.load_level = req_load_level;
      in_item_in.load_index = req_load_index;
      in_item_in.load_edge  = req_load_edge;
      in_item_in.vx         = VEC_W'($signed(req_vec_x <<< SH) >>> SH);
      in_item_in.vy         = VEC_W'($signed(req_vec_y <<< SH) >>> SH);
      in_item_in.vz         = VEC_W'($signed(req_vec_z <<< SH) >>> SH);
      in_item_in.lvl        = (32'(req_search_level) > MAX_LEVEL) ?
                              3'(MAX_LEVEL) : req_search_level;
      in_item_in.zone       = '0;
      in_item_in.not_found  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff  <= req_valid;
         rsp_valid_ff <= chain_valid[MAX_LEVEL] && chain_item[MAX_LEVEL].op == OP_LOCATE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_item_ff        <= in_item_in;
         rsp_zone_ff       <= chain_item[MAX_LEVEL].zone;
         rsp_zone_level_ff <= chain_item[MAX_LEVEL].lvl;
         rsp_not_found_ff  <= chain_item[MAX_LEVEL].not_found;
      end
   end

   spzl_face #(.COMP_BITS(COMP_BITS)) u_face (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_i (in_valid_ff),
      .item_i  (in_item_ff),
      .valid_o (chain_valid[0]),
      .item_o  (chain_item[0])
   );

   for (genvar l = 0; l < MAX_LEVEL; l++) begin : g_level
      spzl_level #(.LEVEL(l)) u_level (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (chain_valid[l]),
         .item_i  (chain_item[l]),
         .valid_o (chain_valid[l+1]),
         .item_o  (chain_item[l+1])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_zone       = rsp_zone_ff;
   assign rsp_zone_level = rsp_zone_level_ff;
   assign rsp_not_found  = rsp_not_found_ff;

   `ASSERT_IMPLY(a_level_sat, clock, reset, rsp_valid, 32'(rsp_zone_level) <= MAX_LEVEL)
   `ASSERT_IMPLY(a_nf_zone, clock, reset, rsp_valid && rsp_not_found, rsp_zone == '0)
   `ASSERT_IMPLY(a_base_zone, clock, reset, rsp_valid && rsp_zone_level == '0, rsp_zone < 13'd20)
   `ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(in_valid_ff))

endmodule

/* src/spzl_face.sv */
module spzl_face import spzl_pkg::*; #(
   parameter int COMP_BITS = COMP_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     valid_i,
   input  item_type item_i,
   output logic     valid_o,
   output item_type item_o
);

   localparam int FRAC = COMP_BITS - 2;
   localparam int CPW  = 2 * FRAC + 2;
   localparam int DW   = CPW + VEC_W + 2;

   logic     s1_valid_ff;
   item_type s1_item_ff;
   logic [2:0] s1_ok_ff [NUM_FACES];
   logic [2:0] s1_ok_in [NUM_FACES];

   logic     s2_valid_ff;
   item_type s2_item_ff;
   item_type s2_item_in;

   always_comb begin
      logic signed [DW-1:0] vv [3];
      logic signed [DW-1:0] dot;
      vv[0] = DW'($signed(item_i.vx));
      vv[1] = DW'($signed(item_i.vy));
      vv[2] = DW'($signed(item_i.vz));
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int e = 0; e < 3; e++) begin
            dot = '0;
            for (int j = 0; j < 3; j++) begin
               dot = dot + DW'(face_cross(f, e, j, FRAC)) * vv[j];
            end
            s1_ok_in[f][e] = !dot[DW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= valid_i;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= item_i;
         s1_ok_ff   <= s1_ok_in;
         s2_item_ff <= s2_item_in;
      end
   end

   // take the first face in table order
   always_comb begin
      s2_item_in           = s1_item_ff;
      s2_item_in.zone      = '0;
      s2_item_in.not_found = 1'b1;
      for (int f = NUM_FACES - 1; f >= 0; f--) begin
         if (&s1_ok_ff[f]) begin
            s2_item_in.zone      = ZONE_W'(f);
            s2_item_in.not_found = 1'b0;
         end
      end
   end

   assign valid_o = s2_valid_ff;
   assign item_o  = s2_item_ff;

endmodule

/* src/spzl_level.sv */
module spzl_level import spzl_pkg::*; #(
   parameter int LEVEL = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     valid_i,
   input  item_type item_i,
   output logic     valid_o,
   output item_type item_o
);

   localparam int XW = 2 * VEC_W + 1;
   localparam int DW = XW + VEC_W + 3;

   logic       b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   item_type   b_item_ff, c_item_ff, d_item_ff, e_item_ff, e_item_in;
   logic [3*VEC_W-1:0] rd_ff [3];
   logic signed [XW-1:0] cr_ff [3][3];
   logic signed [XW-1:0] cr_in [3][3];
   logic [2:0] le_ff;
   logic [2:0] le_in;

   if (LEVEL < STORED_LEVELS) begin : g_store
      localparam int DEPTH = NUM_FACES << (2 * LEVEL);
      localparam int AW    = $clog2(DEPTH);
      logic [3*VEC_W-1:0] mem0 [DEPTH];
      logic [3*VEC_W-1:0] mem1 [DEPTH];
      logic [3*VEC_W-1:0] mem2 [DEPTH];
      logic [AW-1:0]      rd_addr;
      logic [AW-1:0]      wr_addr;
      logic               wr_en;
      logic [3*VEC_W-1:0] wr_data;

      assign rd_addr = item_i.zone[AW-1:0];
      assign wr_addr = item_i.load_index[AW-1:0];
      assign wr_data = {item_i.vz, item_i.vy, item_i.vx};
      assign wr_en   = adv && valid_i && item_i.op == OP_LOAD
                    && item_i.load_level == 2'(LEVEL)
                    && 32'(item_i.load_index) < DEPTH;

      always_ff @(posedge clock) begin
         if (wr_en && item_i.load_edge == 2'd0) begin
            mem0[wr_addr] <= wr_data;
         end
         if (wr_en && item_i.load_edge == 2'd1) begin
            mem1[wr_addr] <= wr_data;
         end
         if (wr_en && item_i.load_edge == 2'd2) begin
            mem2[wr_addr] <= wr_data;
         end
         if (adv) begin
            rd_ff[0] <= mem0[rd_addr];
            rd_ff[1] <= mem1[rd_addr];
            rd_ff[2] <= mem2[rd_addr];
         end
      end
   end else begin : g_nostore
      always_ff @(posedge clock) begin
         if (adv) begin
            rd_ff[0] <= '0;
            rd_ff[1] <= '0;
            rd_ff[2] <= '0;
         end
      end
   end

   // cross products: pair p is (edge p+1) x (edge p+2)
   always_comb begin
      logic signed [XW-1:0] ev [3][3];
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            ev[k][j] = XW'($signed(rd_ff[k][VEC_W*j +: VEC_W]));
         end
      end
      for (int p = 0; p < 3; p++) begin
         for (int j = 0; j < 3; j++) begin
            cr_in[p][j] = ev[NEXT1[p]][NEXT1[j]] * ev[NEXT2[p]][NEXT2[j]]
                        - ev[NEXT1[p]][NEXT2[j]] * ev[NEXT2[p]][NEXT1[j]];
         end
      end
   end

   always_comb begin
      logic signed [DW-1:0] vv [3];
      logic signed [DW-1:0] dot;
      vv[0] = DW'($signed(c_item_ff.vx));
      vv[1] = DW'($signed(c_item_ff.vy));
      vv[2] = DW'($signed(c_item_ff.vz));
      for (int p = 0; p < 3; p++) begin
         dot = '0;
         for (int j = 0; j < 3; j++) begin
            dot = dot + DW'(cr_ff[p][j]) * vv[j];
         end
         le_in[p] = dot[DW-1] || dot == '0;
      end
   end

   always_comb begin
      logic [1:0] child;
      e_item_in = d_item_ff;
      if (le_ff[0]) begin
         child = 2'd0;
      end else if (le_ff[1]) begin
         child = 2'd1;
      end else if (le_ff[2]) begin
         child = 2'd2;
      end else begin
         child = 2'd3;
      end
      if (d_item_ff.op == OP_LOCATE && !d_item_ff.not_found
          && d_item_ff.lvl > 3'(LEVEL)) begin
         e_item_in.zone = {d_item_ff.zone[ZONE_W-3:0], child};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= valid_i;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_item_ff <= item_i;
         c_item_ff <= b_item_ff;
         cr_ff     <= cr_in;
         d_item_ff <= c_item_ff;
         le_ff     <= le_in;
         e_item_ff <= e_item_in;
      end
   end

   assign valid_o = e_valid_ff;
   assign item_o  = e_item_ff;

endmodule

/* dv/sphere_point_zone_locator_tb.sv */
`timescale 1ns / 100ps
module sphere_point_zone_locator_tb;
   import spzl_pkg::*;

   localparam int LAT        = 4 + 4 * MAX_LEVEL_DEF;
   localparam int STALL_LIM  = 2000;
   localparam int HOLD_START = 1500;
   localparam int HOLD_LEN   = 400;
   localparam int QUIET_LO   = 2500;
   localparam int QUIET_HI   = 3500;
   localparam int NUM_ITEMS  = 1900;

   typedef struct {
      bit               op;
      bit [1:0]         lvl;
      bit [10:0]        idx;
      bit [1:0]         edge_sel;
      bit signed [15:0] vx;
      bit signed [15:0] vy;
      bit signed [15:0] vz;
      bit [2:0]         depth;
   } req_item_t;

   typedef struct {
      bit [12:0] zone;
      bit [2:0]  zone_level;
      bit        not_found;
   } zone_result_t;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_op = 0;
   logic [1:0]        req_load_level = 0;
   logic [10:0]       req_load_index = 0;
   logic [1:0]        req_load_edge = 0;
   logic signed [15:0] req_vec_x = 0;
   logic signed [15:0] req_vec_y = 0;
   logic signed [15:0] req_vec_z = 0;
   logic [2:0]        req_search_level = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [12:0]       rsp_zone;
   logic [2:0]        rsp_zone_level;
   logic              rsp_not_found;

   sphere_point_zone_locator u_dut (.*);

   always #5 clock = ~clock;

   req_item_t    pending_q[$];
   zone_result_t zone_expect_q[$];
   longint       mid_store[3][2048][3];
   bit           mid_written[3][2048];
   int           level_base[4]  = '{0, 20, 100, 420};
   int           level_count[4] = '{20, 80, 320, 1280};
   int           errors = 0;
   int           cycle_cnt = 0;
   int           idle_cnt = 0;
   int           locate_cnt = 0;
   int           miss_cnt = 0;
   int           load_cnt = 0;

   function automatic void corner_vec(int k, output longint r[3]);
      longint a;
      longint b;
      a = (CORNER_A_Q30 + 64'sd32768) >>> 16;
      b = (CORNER_B_Q30 + 64'sd32768) >>> 16;
      for (int j = 0; j < 3; j++) begin
         case (CORNER_PATTERN[k][j])
            1:       r[j] = a;
            -1:      r[j] = -a;
            2:       r[j] = b;
            -2:      r[j] = -b;
            default: r[j] = 0;
         endcase
      end
   endfunction

   function automatic int triple_sign(longint a[3], longint b[3], longint v[3]);
      longint t;
      t = (a[1] * b[2] - a[2] * b[1]) * v[0]
        + (a[2] * b[0] - a[0] * b[2]) * v[1]
        + (a[0] * b[1] - a[1] * b[0]) * v[2];
      return t > 0 ? 1 : (t < 0 ? -1 : 0);
   endfunction

   function automatic int base_face(longint v[3]);
      longint c0[3];
      longint c1[3];
      longint c2[3];
      for (int f = 0; f < NUM_FACES; f++) begin
         corner_vec(FACE_TABLE[f][0], c0);
         corner_vec(FACE_TABLE[f][1], c1);
         corner_vec(FACE_TABLE[f][2], c2);
         if (triple_sign(c0, c1, v) >= 0 && triple_sign(c1, c2, v) >= 0 &&
             triple_sign(c2, c0, v) >= 0)
            return f;
      end
      return NUM_FACES;
   endfunction

   function automatic int child_of(int addr, longint v[3]);
      longint e0[3];
      longint e1[3];
      longint e2[3];
      e0 = mid_store[0][addr];
      e1 = mid_store[1][addr];
      e2 = mid_store[2][addr];
      if (triple_sign(e1, e2, v) <= 0) return 0;
      if (triple_sign(e2, e0, v) <= 0) return 1;
      if (triple_sign(e0, e1, v) <= 0) return 2;
      return 3;
   endfunction

   function automatic zone_result_t locate_zone(req_item_t it);
      zone_result_t r;
      longint v[3];
      int face;
      int sl;
      int zone;
      v = '{it.vx, it.vy, it.vz};
      sl = it.depth > MAX_LEVEL_DEF ? MAX_LEVEL_DEF : it.depth;
      face = base_face(v);
      r.zone_level = 3'(sl);
      r.not_found = face == NUM_FACES;
      r.zone = '0;
      if (!r.not_found) begin
         zone = face;
         for (int lev = 0; lev < sl; lev++)
            zone = ((zone << 2) & 'h1fff) + child_of(level_base[lev] + zone, v);
         r.zone = 13'(zone);
      end
      return r;
   endfunction

   task automatic add_item(req_item_t it);
      pending_q.push_back(it);
      if (it.op == OP_LOCATE) begin
         zone_expect_q.push_back(locate_zone(it));
      end else if (it.edge_sel < 3 && it.idx < level_count[it.lvl]) begin
         mid_store[it.edge_sel][level_base[it.lvl] + it.idx] = '{it.vx, it.vy, it.vz};
         mid_written[it.edge_sel][level_base[it.lvl] + it.idx] = 1;
      end
   endtask

   function automatic req_item_t rand_item(bit op);
      req_item_t it;
      it.op = op;
      it.lvl = 2'($urandom);
      it.idx = 11'($urandom);
      it.edge_sel = 2'($urandom_range(0, 2));
      it.vx = 16'($urandom);
      it.vy = 16'($urandom);
      it.vz = 16'($urandom);
      it.depth = 3'($urandom);
      return it;
   endfunction

   task automatic add_load(int lvl, int idx, int e);
      req_item_t it;
      it = rand_item(OP_LOAD);
      it.lvl = 2'(lvl);
      it.idx = 11'(idx);
      it.edge_sel = 2'(e);
      add_item(it);
   endtask

   // fill any midpoint on the descent path before the point goes in
   task automatic add_locate(int x, int y, int z, int depth);
      req_item_t it;
      longint v[3];
      int zone;
      int face;
      int sl;
      it = rand_item(OP_LOCATE);
      it.vx = 16'(x);
      it.vy = 16'(y);
      it.vz = 16'(z);
      it.depth = 3'(depth);
      v = '{it.vx, it.vy, it.vz};
      sl = it.depth > MAX_LEVEL_DEF ? MAX_LEVEL_DEF : it.depth;
      face = base_face(v);
      if (face < NUM_FACES) begin
         zone = face;
         for (int lev = 0; lev < sl; lev++) begin
            for (int e = 0; e < 3; e++)
               if (!mid_written[e][level_base[lev] + zone]) add_load(lev, zone, e);
            zone = zone * 4 + child_of(level_base[lev] + zone, v);
         end
      end
      add_item(it);
   endtask

   initial begin
      req_item_t it;
      int pick;
      add_locate(0, 0, 0, 0);
      add_locate(16384, 0, 0, 1);
      add_locate(0, 16384, 0, 2);
      add_locate(0, 0, 16384, 3);
      add_locate(-16384, 0, 0, 4);
      add_locate(0, -16384, 0, 5);
      add_locate(0, 0, -16384, 7);
      add_locate(-32768, -32768, -32768, 7);
      add_locate(32767, 32767, 32767, 6);
      add_locate(32767, -32768, 32767, 4);
      add_locate(1, 0, 0, 4);
      add_locate(0, 1, -1, 4);
      add_locate(-1, 1, 0, 3);
      add_load(0, 19, 3);
      add_load(0, 20, 0);
      add_load(3, 1279, 2);
      add_load(1, 2047, 1);
      add_load(2, 319, 0);
      add_locate(13938, 8614, 0, 4);
      add_locate(0, 13938, -8614, 4);
      while (pending_q.size() < NUM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            it = rand_item(OP_LOCATE);
            if (pick < 4) begin
               it.vx = 16'(int'($urandom_range(0, 2)) - 1);
               it.vy = 16'(int'($urandom_range(0, 2)) - 1);
               it.vz = 16'(int'($urandom_range(0, 2)) - 1);
            end
            add_locate(it.vx, it.vy, it.vz, it.depth);
         end else if (pick < 88) begin
            pick = $urandom_range(0, 3);
            add_load(pick, int'($urandom_range(0, level_count[pick] - 1)),
                     int'($urandom_range(0, 2)));
         end else if (pick < 94) begin
            pick = $urandom_range(0, 3);
            add_load(pick, int'($urandom_range(level_count[pick], 2047)),
                     int'($urandom_range(0, 2)));
         end else begin
            add_load(int'($urandom_range(0, 3)), int'($urandom_range(0, 2047)), 3);
         end
      end
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (pending_q.size() == 0 && !req_valid && zone_expect_q.size() == 0);
      repeat (2 * LAT) @(posedge clock);
      $display("Sent %0d midpoint loads and %0d point lookups, %0d of them off every face.",
               load_cnt, locate_cnt, miss_cnt);
      $display("Lookups covered every search depth, extreme components and backpressure.");
      if (errors == 0 && zone_expect_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   function automatic bit may_idle();
      return !(cycle_cnt >= QUIET_LO && cycle_cnt < QUIET_HI) && $urandom_range(0, 99) < 28;
   endfunction

   always @(posedge clock) begin
      req_item_t it;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_q.size() > 0 && !may_idle()) begin
            it = pending_q.pop_front();
            req_valid <= 1;
            req_op <= it.op;
            req_load_level <= it.lvl;
            req_load_index <= it.idx;
            req_load_edge <= it.edge_sel;
            req_vec_x <= it.vx;
            req_vec_y <= it.vy;
            req_vec_z <= it.vz;
            req_search_level <= it.depth;
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 0;
      else if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_LEN)
         rsp_ready <= 0;
      else
         rsp_ready <= !may_idle();
   end

   always @(posedge clock) begin
      zone_result_t want;
      if (!reset) begin
         cycle_cnt <= cycle_cnt + 1;
         if (req_valid && req_ready) begin
            if (req_op == OP_LOCATE) locate_cnt <= locate_cnt + 1;
            else load_cnt <= load_cnt + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (zone_expect_q.size() == 0) begin
               $error("result transfer with nothing outstanding: zone %0d", rsp_zone);
               errors = errors + 1;
            end else begin
               want = zone_expect_q.pop_front();
               if (want.not_found) miss_cnt <= miss_cnt + 1;
               if (rsp_zone !== want.zone) begin
                  $error("zone: expected %0d, got %0d", want.zone, rsp_zone);
                  errors = errors + 1;
               end
               if (rsp_zone_level !== want.zone_level) begin
                  $error("zone_level: expected %0d, got %0d", want.zone_level,
                         rsp_zone_level);
                  errors = errors + 1;
               end
               if (rsp_not_found !== want.not_found) begin
                  $error("not_found: expected %0d, got %0d", want.not_found,
                         rsp_not_found);
                  errors = errors + 1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cnt <= 0;
         end else if (idle_cnt >= STALL_LIM) begin
            $display("Run stalled: %0d cycles without a transfer.", idle_cnt);
            $display("FAIL");
            $finish;
         end else begin
            idle_cnt <= idle_cnt + 1;
         end
      end
   end

endmodule
